// ----- rtl/core/mmsn_pkg.sv -----
// Shared types and constants of the median/mean sensor normalizer.
// Used by mmsn_ctrl, mmsn_dp and median_mean_sensor_normalizer_top.
`default_nettype none

package mmsn_pkg;

   // Block dimensions
   localparam int CHANNELS    = 6;
   localparam int CEIL_REGS   = 6;
   localparam int ROUNDS      = 10;
   localparam int SAMPLE_BITS = 12;
   localparam int REG_W       = 12;
   localparam int CH_W        = 3;
   localparam int SUM_W       = 16;
   localparam int CNT_W       = 4;
   localparam int LEVEL_W     = 14;
   localparam int NUM_W       = SUM_W + LEVEL_W;
   localparam int DIVCNT_W    = $clog2(LEVEL_W);
   localparam int CH_IDX_W    = $clog2(CHANNELS);
   localparam int CEIL_IDX_W  = $clog2(CEIL_REGS);
   localparam int CSR_ADDR_W  = 3;
   // Three samples padded up to whole bytes
   localparam int REQ_TDATA_W = ((3*SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
   localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(10000);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOOR     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CEIL_BASE = 3'd1;

   // Ceiling values after reset, channel 0 first
   localparam logic [REG_W-1:0] CEIL_RESET [CEIL_REGS] = '{
      12'd1380, 12'd1226, 12'd1440, 12'd1343, 12'd1340, 12'd1594
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MULT,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic mult;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ch_ok;
      logic round_done;
      logic need_div;
      logic div_last;
      logic out_full;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/mmsn_ctrl.sv -----
// Sequencer of the normalizer: accept, update, multiply, divide, deliver.
// Depends on mmsn_pkg; drives mmsn_dp through cmd_type commands.
`default_nettype none

module mmsn_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               rsp_tready,
   input  wire mmsn_pkg::stat_type stat,
   output mmsn_pkg::cmd_type       cmd
);
   import mmsn_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // take no transfer while reset is held
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
            if (req_tvalid && !reset) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            priority if (!stat.ch_ok || !stat.round_done) begin
               state_in = ST_IDLE;
            end else if (stat.need_div) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait until the output register is free or being drained
            if (!stat.out_full || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/mmsn_dp.sv -----
// Datapath of the normalizer: config registers, per-channel sums and counts,
// median, scaling multiplier, restoring divider and output register. Uses mmsn_pkg.
`default_nettype none

module mmsn_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mmsn_pkg::cmd_type                     cmd,
   output mmsn_pkg::stat_type                         stat,
   input  wire logic                                  csr_we,
   input  wire logic [mmsn_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [mmsn_pkg::REG_W-1:0]            csr_wdata,
   input  wire logic [mmsn_pkg::CH_W-1:0]             in_channel,
   input  wire logic [3*mmsn_pkg::SAMPLE_BITS-1:0]    in_samples,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [mmsn_pkg::CH_W-1:0]                  out_channel,
   output logic [mmsn_pkg::LEVEL_W-1:0]               out_level,
   output logic                                       out_over,
   output logic                                       out_bad
);
   import mmsn_pkg::*;

   // Configuration
   logic [REG_W-1:0] floor_ff;
   logic [REG_W-1:0] ceil_ff [CEIL_REGS];
   logic [CSR_ADDR_W-1:0] ceil_sel;

   // Per-channel state
   logic [SUM_W-1:0] sum_ff [CHANNELS];
   logic [CNT_W-1:0] cnt_ff [CHANNELS];

   // Captured item
   logic [CH_W-1:0]        ch_ff;
   logic [SAMPLE_BITS-1:0] sa_ff, sb_ff, sc_ff;

   // Round result and divider
   logic [LEVEL_W-1:0]  level_ff;
   logic                over_ff, bad_ff;
   logic [SUM_W-1:0]    diff_ff, den_ff, rem_ff;
   logic [LEVEL_W-1:0]  quo_ff;
   logic [DIVCNT_W-1:0] divcnt_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [CH_W-1:0]     o_ch_ff;
   logic [LEVEL_W-1:0]  o_level_ff;
   logic                o_over_ff, o_bad_ff;

   // Combinational terms
   logic [CH_IDX_W-1:0]    ch_idx;
   logic [SAMPLE_BITS-1:0] lo, hi, med;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_new;
   logic [CNT_W:0]         cnt_new;
   logic [REG_W-1:0]       ceil_cur;
   logic [SUM_W-1:0]       base, top;
   logic                   bad_c, over_c, below_c;
   logic [NUM_W-1:0]       product;
   logic [SUM_W:0]         trial;
   logic                   trial_ge;

   assign ceil_sel = csr_addr - CSR_CEIL_BASE;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         for (int i = 0; i < CEIL_REGS; i++) begin
            ceil_ff[i] <= CEIL_RESET[i];
         end
      end else if (csr_we) begin
         if (csr_addr == CSR_FLOOR) begin
            floor_ff <= csr_wdata;
         end else if (csr_addr >= CSR_CEIL_BASE &&
                      ({1'b0, csr_addr} < 4'(CSR_CEIL_BASE) + 4'(CEIL_REGS))) begin
            ceil_ff[ceil_sel[CEIL_IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff <= in_channel;
         sa_ff <= in_samples[SAMPLE_BITS-1:0];
         sb_ff <= in_samples[2*SAMPLE_BITS-1:SAMPLE_BITS];
         sc_ff <= in_samples[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      end
   end

   assign ch_idx = ch_ff[CH_IDX_W-1:0];

   // Median of three, saturating sum, next count, calibration checks
   always_comb begin
      lo = (sa_ff < sb_ff) ? sa_ff : sb_ff;
      hi = (sa_ff < sb_ff) ? sb_ff : sa_ff;
      priority if (sc_ff > hi) begin
         med = hi;
      end else if (sc_ff > lo) begin
         med = sc_ff;
      end else begin
         med = lo;
      end
      stat.ch_ok = ({1'b0, ch_ff} < 4'(CHANNELS)) && ({1'b0, ch_ff} < 4'(CEIL_REGS));
      if (stat.ch_ok) begin
         sum_wide = {1'b0, sum_ff[ch_idx]} + (SUM_W+1)'(med);
         cnt_new  = {1'b0, cnt_ff[ch_idx]} + (CNT_W+1)'(1);
         ceil_cur = ceil_ff[ch_idx];
      end else begin
         sum_wide = '0;
         cnt_new  = '0;
         ceil_cur = '0;
      end
      sum_new = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      stat.round_done = cnt_new >= (CNT_W+1)'(ROUNDS);
      base    = SUM_W'(floor_ff) * SUM_W'(ROUNDS);
      top     = SUM_W'(ceil_cur) * SUM_W'(ROUNDS);
      bad_c   = ceil_cur <= floor_ff;
      over_c  = !bad_c && (sum_new > top);
      below_c = !bad_c && !over_c && (sum_new <= base);
      stat.need_div = !bad_c && !over_c && !below_c;
      stat.div_last = divcnt_ff == DIVCNT_W'(LEVEL_W - 1);
      stat.out_full = rsp_valid_ff;
   end

   // Advance the per-channel sums and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.update && stat.ch_ok) begin
         if (stat.round_done) begin
            sum_ff[ch_idx] <= '0;
            cnt_ff[ch_idx] <= '0;
         end else begin
            sum_ff[ch_idx] <= sum_new;
            cnt_ff[ch_idx] <= cnt_new[CNT_W-1:0];
         end
      end
   end

   // Scale and divide: quotient fits LEVEL_W bits, so the upper product
   // bits start as the partial remainder
   assign product  = NUM_W'(diff_ff) * NUM_W'(FULL_SCALE);
   assign trial    = {rem_ff, quo_ff[LEVEL_W-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         level_ff <= over_c ? FULL_SCALE : '0;
         over_ff  <= over_c;
         bad_ff   <= bad_c;
         diff_ff  <= sum_new - base;
         den_ff   <= top - base;
      end
      if (cmd.mult) begin
         rem_ff    <= product[NUM_W-1:LEVEL_W];
         quo_ff    <= product[LEVEL_W-1:0];
         divcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff    <= trial_ge ? SUM_W'(trial - {1'b0, den_ff}) : trial[SUM_W-1:0];
         quo_ff    <= {quo_ff[LEVEL_W-2:0], trial_ge};
         divcnt_ff <= divcnt_ff + DIVCNT_W'(1);
         if (stat.div_last) begin
            level_ff <= {quo_ff[LEVEL_W-2:0], trial_ge};
         end
      end
   end

   // Output register: free on transfer, load from the finished round
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_ch_ff    <= ch_ff;
         o_level_ff <= level_ff;
         o_over_ff  <= over_ff;
         o_bad_ff   <= bad_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign out_channel   = o_ch_ff;
   assign out_level     = o_level_ff;
   assign out_over      = o_over_ff;
   assign out_bad       = o_bad_ff;

   // Divider remainder stays below the divisor while stepping
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   // Reported level never exceeds full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> o_level_ff <= FULL_SCALE)
      else $error("level above full scale");

   // Saturation flag comes with full scale, bad calibration with zero
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!o_over_ff || o_level_ff == FULL_SCALE) &&
                       (!o_bad_ff || (o_level_ff == '0 && !o_over_ff)))
      else $error("flags disagree with level");

   // A loaded result is on the port in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- rtl/core/median_mean_sensor_normalizer_top.sv -----
// Top level of the median/mean sensor normalizer.
// Instantiates mmsn_ctrl and mmsn_dp; uses mmsn_pkg.
//
//   channel  dir  signals                          payload
//   req      in   req_tvalid/tready/tdata/tuser    three samples, channel
//   rsp      out  rsp_tvalid/tready/tdata/tuser    level and flags, channel
//   csr      in   csr_we/csr_addr/csr_wdata        register index and value
//
// A round that does not close its channel passes through accept and update.
// A closing round passes through accept, update and load with a clamped or flagged level,
// or through accept, update, scale multiply, 14 divide steps and load when the 14-step
// restoring divider runs, one quotient bit per cycle.
// The result waits in an output register; a stalled rsp holds the next
// closing round in its load state. Reset is synchronous and clears all sums.
`default_nettype none

module median_mean_sensor_normalizer_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // sample_first, sample_second, sample_third, zero pad
   input  wire logic [mmsn_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // channel
   input  wire logic [mmsn_pkg::CH_W-1:0]             req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // level_hundredths, over_ceiling, bad_calibration
   output logic [mmsn_pkg::LEVEL_W+1:0]               rsp_tdata,
   // out_channel
   output logic [mmsn_pkg::CH_W-1:0]                  rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [mmsn_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [mmsn_pkg::REG_W-1:0]            csr_wdata
);
   import mmsn_pkg::*;

   cmd_type            cmd;
   stat_type           stat;
   logic [LEVEL_W-1:0] level;
   logic               over, bad;

   mmsn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mmsn_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .in_channel  (req_tuser),
      .in_samples  (req_tdata[3*SAMPLE_BITS-1:0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_channel (rsp_tuser),
      .out_level   (level),
      .out_over    (over),
      .out_bad     (bad)
   );

   assign rsp_tdata = {bad, over, level};

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for median_mean_sensor_normalizer_top.
// Predicts each channel's normalized level in a scoreboard class, drives the
// req and rsp ports with random gaps, programs the csr port and checks every result transfer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmsn_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int LONG_HOLD       = 400;
   localparam int ROUNDS_PER_PHASE = 72;
   localparam int LAST_PHASE      = 7;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
   // Index past the register list; writes there must have no effect
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [CH_W-1:0]    ch;
      logic [LEVEL_W-1:0] level;
      logic               over;
      logic               bad;
   } level_result_type;

   // Channel state, register copies and the queue of expected levels
   class level_scoreboard;
      logic [REG_W-1:0] floor_reg;
      logic [REG_W-1:0] ceiling_reg [CEIL_REGS];
      logic [SUM_W-1:0] median_sum [CHANNELS];
      logic [CNT_W-1:0] round_count [CHANNELS];
      level_result_type expected_levels [$];
      int               errors;

      function new();
         floor_reg      = '0;
         ceiling_reg[0] = 12'd1380;
         ceiling_reg[1] = 12'd1226;
         ceiling_reg[2] = 12'd1440;
         ceiling_reg[3] = 12'd1343;
         ceiling_reg[4] = 12'd1340;
         ceiling_reg[5] = 12'd1594;
         for (int i = 0; i < CHANNELS; i++) begin
            median_sum[i]  = '0;
            round_count[i] = '0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [REG_W-1:0] value);
         if (index == CSR_FLOOR)
            floor_reg = value;
         else if (index >= CSR_CEIL_BASE && int'(index) < int'(CSR_CEIL_BASE) + CEIL_REGS)
            ceiling_reg[index - CSR_CEIL_BASE] = value;
      endfunction

      // Fold one accepted round into its channel; close the channel on the last round
      function void add_round(logic [CH_W-1:0] ch, logic [SAMPLE_BITS-1:0] a,
                              logic [SAMPLE_BITS-1:0] b, logic [SAMPLE_BITS-1:0] c);
         logic [SAMPLE_BITS-1:0] lo, hi, med;
         int               total, rounds_taken;
         longint           base, top, lvl;
         level_result_type r;
         if (int'(ch) >= CHANNELS || int'(ch) >= CEIL_REGS) return;
         lo  = (a < b) ? a : b;
         hi  = (a < b) ? b : a;
         med = (c > hi) ? hi : ((c > lo) ? c : lo);
         total = int'(median_sum[ch]) + int'(med);
         if (total > int'(SUM_MAX)) total = int'(SUM_MAX);
         rounds_taken = int'(round_count[ch]) + 1;
         if (rounds_taken < ROUNDS) begin
            median_sum[ch]  = SUM_W'(total);
            round_count[ch] = CNT_W'(rounds_taken);
            return;
         end
         r.ch    = ch;
         r.level = '0;
         r.over  = 1'b0;
         r.bad   = 1'b0;
         if (ceiling_reg[ch] <= floor_reg) begin
            r.bad = 1'b1;
         end else begin
            base = longint'(ROUNDS) * longint'(floor_reg);
            top  = longint'(ROUNDS) * longint'(ceiling_reg[ch]);
            if (longint'(total) > top) begin
               r.over  = 1'b1;
               r.level = FULL_SCALE;
            end else if (longint'(total) > base) begin
               lvl = longint'(FULL_SCALE) * (longint'(total) - base) / (top - base);
               if (lvl > longint'(FULL_SCALE)) lvl = longint'(FULL_SCALE);
               r.level = LEVEL_W'(lvl);
            end
         end
         median_sum[ch]  = '0;
         round_count[ch] = '0;
         expected_levels.push_back(r);
      endfunction

      // Compare one result transfer with the oldest expected level
      function void check_level(logic [CH_W-1:0] ch, logic [LEVEL_W+1:0] data);
         level_result_type want;
         if (expected_levels.size() == 0) begin
            $error("unexpected result transfer: out_channel %0d data 0x%h", ch, data);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         if (ch !== want.ch) begin
            $error("out_channel: expected %0d, actual %0d", want.ch, ch);
            errors++;
         end
         if (data[LEVEL_W-1:0] !== want.level) begin
            $error("level_hundredths: expected %0d, actual %0d", want.level,
                   data[LEVEL_W-1:0]);
            errors++;
         end
         if (data[LEVEL_W] !== want.over) begin
            $error("over_ceiling: expected %0b, actual %0b", want.over, data[LEVEL_W]);
            errors++;
         end
         if (data[LEVEL_W+1] !== want.bad) begin
            $error("bad_calibration: expected %0b, actual %0b", want.bad, data[LEVEL_W+1]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_W-1:0]      req_tdata = '0;   // sample_first, sample_second, sample_third
   logic [CH_W-1:0]             req_tuser = '0;   // channel
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [LEVEL_W+1:0]          rsp_tdata;        // level_hundredths, over_ceiling, bad_calibration
   logic [CH_W-1:0]             rsp_tuser;        // out_channel
   logic                        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_addr = '0;
   logic [REG_W-1:0]            csr_wdata = '0;

   level_scoreboard  levels;
   int               hold_requests = 0;
   int               holds_served = 0;
   int               rsp_stall_left = 0;
   int               rsp_burst_left = 0;
   int               cycle_count = 0;
   logic [REG_W-1:0] next_floor;
   logic [REG_W-1:0] next_ceiling [CEIL_REGS];

   median_mean_sensor_normalizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample inside the calibrated window 45 in 100 times, with full-range and edge noise
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(int lo, int hi);
      int pick, v;
      pick = $urandom_range(0, 99);
      if (pick < 35) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      if (pick < 80) return SAMPLE_BITS'($urandom_range(lo, hi));
      if (pick < 90) return $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      v = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return SAMPLE_BITS'(v);
   endfunction

   // Result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      int pick;
      if (!reset && rsp_tvalid && rsp_tready)
         levels.check_level(rsp_tuser, rsp_tdata);
      if (holds_served != hold_requests) begin
         holds_served   <= holds_served + 1;
         rsp_stall_left <= LONG_HOLD;
         rsp_tready     <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else if (rsp_burst_left > 0) begin
         rsp_burst_left <= rsp_burst_left - 1;
         rsp_tready     <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            rsp_burst_left <= $urandom_range(30, 80);
         else if (pick < 40)
            rsp_stall_left <= pick_gap();
      end
   end

   // Give up on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Write one register; the write lands at the next edge
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      levels.write_reg(index, value);
   endtask

   task automatic program_regs();
      write_reg(CSR_FLOOR, next_floor);
      for (int i = 0; i < CEIL_REGS; i++)
         write_reg(CSR_CEIL_BASE + CSR_ADDR_W'(i), next_ceiling[i]);
      csr_we <= 1'b0;
   endtask

   // Offer one round after an optional gap and hold it until the transfer
   task automatic send_round(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] s1,
                             input logic [SAMPLE_BITS-1:0] s2,
                             input logic [SAMPLE_BITS-1:0] s3, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ch;
      req_tdata  <= REQ_TDATA_W'({s3, s2, s1});
      do @(posedge clock); while (!req_tready);
      levels.add_round(ch, s1, s2, s3);
   endtask

   // Stop offering, wait for every expected level, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (levels.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_rounds(input int count, input bit steady);
      int               sent, lo, hi, gap;
      logic [CH_W-1:0]  ch;
      sent = 0;
      while (sent < count) begin
         gap = steady ? 0 : pick_gap();
         if ($urandom_range(0, 99) < 5) begin
            // Channels without a ceiling register are dropped by the block
            ch = CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
            send_round(ch, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                       SAMPLE_BITS'($urandom), gap);
         end else begin
            ch = CH_W'($urandom_range(0, CHANNELS - 1));
            lo = int'(levels.floor_reg);
            hi = int'(levels.ceiling_reg[ch]);
            if (lo > hi) begin
               lo = hi;
               hi = int'(levels.floor_reg);
            end
            send_round(ch, pick_sample(lo, hi), pick_sample(lo, hi), pick_sample(lo, hi),
                       gap);
            sent++;
         end
      end
   endtask

   initial begin
      levels = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: dropped channels, then one saturating and one empty channel
      send_round(3'd6, 12'd4095, 12'd0, 12'd4095, 0);
      send_round(3'd7, 12'd0, 12'd4095, 12'd0, 0);
      send_round(3'd0, 12'd0, 12'd2048, 12'd4095, 0);
      send_round(3'd0, 12'd0, 12'd4095, 12'd2048, 0);
      send_round(3'd0, 12'd2048, 12'd0, 12'd4095, 0);
      send_round(3'd0, 12'd2048, 12'd4095, 12'd0, 0);
      send_round(3'd0, 12'd4095, 12'd0, 12'd2048, 0);
      send_round(3'd0, 12'd4095, 12'd2048, 12'd0, 0);
      for (int i = 0; i < 4; i++)
         send_round(3'd0, 12'd4095, 12'd4095, 12'd4095, 0);
      for (int i = 0; i < ROUNDS; i++)
         send_round(3'd1, 12'd0, 12'd0, 12'd0, i % 2);
      random_rounds(ROUNDS_PER_PHASE, 1'b0);
      drain();

      // Random phases, each under its own calibration
      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         case (phase)
            1: begin
               // floor at the top: every channel is badly calibrated
               next_floor = 12'd4095;
               for (int i = 0; i < CEIL_REGS; i++)
                  next_ceiling[i] = REG_W'($urandom_range(0, SAMPLE_MAX));
            end
            2: begin
               next_floor = '0;
               for (int i = 0; i < CEIL_REGS; i++) next_ceiling[i] = 12'd4095;
            end
            3: begin
               // ceiling equal to and below the floor on two channels
               next_floor = REG_W'($urandom_range(300, 1500));
               next_ceiling[0] = next_floor;
               next_ceiling[1] = next_floor - 1'b1;
               for (int i = 2; i < CEIL_REGS; i++)
                  next_ceiling[i] = next_floor + REG_W'($urandom_range(1, 2000));
            end
            4: begin
               next_floor = '0;
               for (int i = 0; i < CEIL_REGS; i++) next_ceiling[i] = '0;
            end
            5: begin
               next_floor = REG_W'($urandom_range(0, SAMPLE_MAX));
               for (int i = 0; i < CEIL_REGS; i++)
                  next_ceiling[i] = REG_W'($urandom_range(0, SAMPLE_MAX));
            end
            6: begin
               // narrowest span on even channels
               next_floor = 12'd1000;
               for (int i = 0; i < CEIL_REGS; i++)
                  next_ceiling[i] = (i % 2 == 0) ? 12'd1001 : 12'd4095;
            end
            default: begin
               next_floor = REG_W'($urandom_range(0, 2000));
               for (int i = 0; i < CEIL_REGS; i++)
                  next_ceiling[i] = next_floor +
                                    REG_W'($urandom_range(1, SAMPLE_MAX - int'(next_floor)));
            end
         endcase
         if (phase == 5) begin
            write_reg(CSR_UNUSED, REG_W'($urandom));
            csr_we <= 1'b0;
         end
         program_regs();
         // Starve the result side while rounds keep coming
         if (phase == 2 || phase == 5)
            hold_requests <= hold_requests + 1;
         random_rounds(ROUNDS_PER_PHASE, $urandom_range(0, 3) == 0);
         drain();
      end

      if (levels.errors == 0 && levels.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/core/mmsn_pkg.sv
rtl/core/mmsn_ctrl.sv
rtl/core/mmsn_dp.sv
rtl/core/median_mean_sensor_normalizer_top.sv
tb/sv/tb.sv
